[rtl/demand_paging_fifo_lru_mmu_defines.svh]
// Assertion macros for the demand paging MMU.
// Depends on nothing; included by the top level, which supplies clock and reset.
`ifndef DEMAND_PAGING_FIFO_LRU_MMU_DEFINES_SVH
`define DEMAND_PAGING_FIFO_LRU_MMU_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DPFL_ASSERT_NOW(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("dpfl: same-cycle check failed");
`define DPFL_ASSERT_NEXT(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("dpfl: next-cycle check failed");
`else
`define DPFL_ASSERT_NOW(lbl, ant, cons)
`define DPFL_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

[rtl/dpfl_pkg.sv]
// Shared types and sizing constants for the demand paging MMU.
// Depends on nothing; used by the top level of the block.
package dpfl_pkg;
   localparam int VIRTUAL_PAGES = 8;
   localparam int FRAMES        = 4;
   localparam int PAGE_WORDS    = 8;
   localparam int DATA_BITS     = 32;
   localparam int CLOCK_BITS    = 16;

   typedef struct packed {
      logic [0:0]         opcode;
      logic [5:0]         virtual_address;
      logic signed [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_data;
      logic               page_fault;
      logic               evicted;
      logic [1:0]         frame_used;
   } rsp_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
endpackage

[rtl/dpfl_ram.sv]
// Simple dual-port synchronous RAM: one write and one registered read per cycle.
// Depends on nothing; instantiated by the top level for frame and backing storage.
module dpfl_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/demand_paging_fifo_lru_mmu.sv]
// Top level of the demand paging MMU: page table, frame tables and sequencer.
// Depends on dpfl_pkg, dpfl_ram and demand_paging_fifo_lru_mmu_defines.svh.
//
// Usage: a word is accepted on req_word when start is high and busy is low.
// It carries a read or write of one data word at a 6-bit virtual address.
// Exactly one result word follows on rsp_word, marked by rsp_valid for one
// cycle; the receiver must take it then, since it cannot stall the block.
// The one configuration register, the replacement policy (0 FIFO, 1 LRU), is
// written with csr_we and csr_wdata; the user must write it only while the
// block is idle, since the block itself does not enforce this.
// From acceptance to the strobe, a hit goes through the access and done states.
// A fault into a free frame first loads the page from backing memory. A fault
// with all frames full first scans the frames for a victim and writes the
// victim page back before the load. The page copies go one word per cycle
// through the single read port of each memory.
// Reset clears the page table valid and dirty bits, the frame in-use bits, the access clock and policy.
// Backing pages that were never written back read as all ones through one
// valid bit per page; frame memory is always loaded before it is read.
module demand_paging_fifo_lru_mmu (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dpfl_pkg::req_type req_word,
   input  logic              csr_we,
   input  logic              csr_wdata,
   output logic              rsp_valid,
   output dpfl_pkg::rsp_type rsp_word
);
   import dpfl_pkg::*;

   localparam int WORD_BITS  = $clog2(PAGE_WORDS);
   localparam int PAGE_BITS  = $clog2(VIRTUAL_PAGES);
   localparam int FRAME_BITS = $clog2(FRAMES);
   localparam int CNT_BITS   = $clog2(PAGE_WORDS + 1);
   localparam int FA_BITS    = $clog2(FRAMES * PAGE_WORDS);
   localparam int BA_BITS    = $clog2(VIRTUAL_PAGES * PAGE_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_WB, ST_LOAD, ST_ACCESS, ST_DONE
   } state_type;

   state_type               state_ff;
   req_type                 req_ff;
   logic [PAGE_BITS-1:0]    page_ff;
   logic [WORD_BITS-1:0]    word_ff;
   logic [FRAME_BITS-1:0]   frame_ff;
   logic [PAGE_BITS-1:0]    owner_ff;
   logic                    fault_ff;
   logic                    evict_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [FRAME_BITS-1:0]   scan_ff;
   logic [FRAME_BITS-1:0]   best_ff;
   logic [CLOCK_BITS-1:0]   best_time_ff;
   logic                    policy_ff;
   logic [CLOCK_BITS-1:0]   clock_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   // Page table and frame bookkeeping.
   logic                    entry_valid_ff [VIRTUAL_PAGES];
   logic                    entry_dirty_ff [VIRTUAL_PAGES];
   logic [FRAME_BITS-1:0]   entry_frame_ff [VIRTUAL_PAGES];
   logic                    bk_row_valid_ff [VIRTUAL_PAGES];
   logic                    in_use_ff [FRAMES];
   logic [PAGE_BITS-1:0]    owner_page_ff [FRAMES];
   logic [CLOCK_BITS-1:0]   load_time_ff [FRAMES];
   logic [CLOCK_BITS-1:0]   use_time_ff [FRAMES];

   // Memory ports.
   logic                    f_we, b_we;
   logic [FA_BITS-1:0]      f_waddr, f_raddr;
   logic [BA_BITS-1:0]      b_waddr, b_raddr;
   logic [DATA_BITS-1:0]    f_wdata, f_rdata, b_wdata, b_rdata;

   logic [PAGE_BITS-1:0]    in_page;
   logic [WORD_BITS-1:0]    in_word;
   logic                    any_free;
   logic [FRAME_BITS-1:0]   free_frame;
   logic [CLOCK_BITS-1:0]   scan_time;
   logic [FRAME_BITS-1:0]   best_in;
   logic [CLOCK_BITS-1:0]   best_time_in;
   logic [WORD_BITS-1:0]    rd_idx, wr_idx;
   logic                    copy_last;

   assign in_word = req_word.virtual_address[WORD_BITS-1:0];
   assign in_page = PAGE_BITS'(req_word.virtual_address >> WORD_BITS);

   // Lowest-numbered free frame.
   always_comb begin
      any_free   = 1'b0;
      free_frame = '0;
      for (int f = FRAMES - 1; f >= 0; f--) begin
         if (!in_use_ff[f]) begin
            any_free   = 1'b1;
            free_frame = FRAME_BITS'(f);
         end
      end
   end

   // One frame per cycle is compared against the best so far; strict less-than
   // keeps ties on the lower frame.
   assign scan_time = policy_ff ? use_time_ff[scan_ff] : load_time_ff[scan_ff];
   always_comb begin
      best_in      = best_ff;
      best_time_in = best_time_ff;
      if (scan_time < best_time_ff) begin
         best_in      = scan_ff;
         best_time_in = scan_time;
      end
   end

   // During a page copy, reads are issued at the count and the word read in the
   // previous cycle is written one index behind.
   assign rd_idx    = cnt_ff[WORD_BITS-1:0];
   assign wr_idx    = WORD_BITS'(cnt_ff - 1'b1);
   assign copy_last = (cnt_ff == CNT_BITS'(PAGE_WORDS));

   always_comb begin
      f_raddr = {frame_ff, rd_idx};
      if (state_ff == ST_ACCESS) begin
         f_raddr = {frame_ff, word_ff};
      end
      f_we    = 1'b0;
      f_waddr = {frame_ff, wr_idx};
      f_wdata = bk_row_valid_ff[page_ff] ? b_rdata : '1;
      if (state_ff == ST_LOAD && cnt_ff != '0) begin
         f_we = 1'b1;
      end else if (state_ff == ST_ACCESS && req_ff.opcode == OP_WRITE) begin
         f_we    = 1'b1;
         f_waddr = {frame_ff, word_ff};
         f_wdata = DATA_BITS'(req_ff.write_data);
      end
      b_raddr = {page_ff, rd_idx};
      b_we    = (state_ff == ST_WB) && (cnt_ff != '0);
      b_waddr = {owner_ff, wr_idx};
      b_wdata = f_rdata;
   end

   dpfl_ram #(.DEPTH(FRAMES * PAGE_WORDS), .WIDTH(DATA_BITS)) u_frame_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   dpfl_ram #(.DEPTH(VIRTUAL_PAGES * PAGE_WORDS), .WIDTH(DATA_BITS)) u_backing_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_ff   <= req_word;
               page_ff  <= in_page;
               word_ff  <= in_word;
               evict_ff <= 1'b0;
               cnt_ff   <= '0;
               if (entry_valid_ff[in_page]) begin
                  frame_ff <= entry_frame_ff[in_page];
                  fault_ff <= 1'b0;
                  state_ff <= ST_ACCESS;
               end else if (any_free) begin
                  frame_ff <= free_frame;
                  fault_ff <= 1'b1;
                  state_ff <= ST_LOAD;
               end else begin
                  fault_ff     <= 1'b1;
                  scan_ff      <= FRAME_BITS'(1);
                  best_ff      <= '0;
                  best_time_ff <= policy_ff ? use_time_ff[0] : load_time_ff[0];
                  state_ff     <= ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            best_ff      <= best_in;
            best_time_ff <= best_time_in;
            scan_ff      <= scan_ff + 1'b1;
            if (scan_ff == FRAME_BITS'(FRAMES - 1)) begin
               frame_ff <= best_in;
               owner_ff <= owner_page_ff[best_in];
               state_ff <= ST_WB;
            end
         end
         ST_WB: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (copy_last) begin
               entry_valid_ff[owner_ff]  <= 1'b0;
               entry_dirty_ff[owner_ff]  <= 1'b0;
               bk_row_valid_ff[owner_ff] <= 1'b1;
               in_use_ff[frame_ff]       <= 1'b0;
               evict_ff                  <= 1'b1;
               cnt_ff                    <= '0;
               state_ff                  <= ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (copy_last) begin
               entry_valid_ff[page_ff] <= 1'b1;
               entry_frame_ff[page_ff] <= frame_ff;
               in_use_ff[frame_ff]     <= 1'b1;
               owner_page_ff[frame_ff] <= page_ff;
               load_time_ff[frame_ff]  <= clock_ff;
               state_ff                <= ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (req_ff.opcode == OP_WRITE) begin
               entry_dirty_ff[page_ff] <= 1'b1;
            end
            use_time_ff[frame_ff] <= clock_ff;
            if (clock_ff != '1) begin
               clock_ff <= clock_ff + 1'b1;
            end
            state_ff <= ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_ff         <= 1'b1;
            rsp_ff.read_data     <= (req_ff.opcode == OP_WRITE) ? '0 : 32'(signed'(f_rdata));
            rsp_ff.page_fault    <= fault_ff;
            rsp_ff.evicted       <= evict_ff;
            rsp_ff.frame_used    <= 2'(frame_ff);
            state_ff             <= ST_IDLE;
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (csr_we) begin
         policy_ff <= csr_wdata;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= 1'b0;
         clock_ff     <= '0;
         for (int p = 0; p < VIRTUAL_PAGES; p++) begin
            entry_valid_ff[p]  <= 1'b0;
            entry_dirty_ff[p]  <= 1'b0;
            bk_row_valid_ff[p] <= 1'b0;
         end
         for (int f = 0; f < FRAMES; f++) begin
            in_use_ff[f] <= 1'b0;
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // An accepted word always keeps the block busy in the following cycle.
   `include "demand_paging_fifo_lru_mmu_defines.svh"
   `DPFL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // A result is shown only once the sequencer is back in idle.
   `DPFL_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)
   // The strobe lasts one cycle, since no two results can be adjacent.
   `DPFL_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid)
   // An eviction only happens as part of a page fault.
   `DPFL_ASSERT_NOW(a_evict_fault, rsp_valid && rsp_word.evicted, rsp_word.page_fault)
endmodule
